>>> design/circular_deque_unit_defines.svh
// Assertion macros shared by the deque unit's modules.
`ifndef CIRCULAR_DEQUE_UNIT_DEFINES_SVH
`define CIRCULAR_DEQUE_UNIT_DEFINES_SVH

// Check on every rising clock edge except while reset is high.
`define CDQ_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check on every rising clock edge, including edges during reset.
`define CDQ_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> design/cdq_pkg.sv
// Types and constants for the circular deque unit.
package cdq_pkg;

   localparam int VALUE_W = 32;
   localparam int OCC_W   = 4;

   typedef enum logic [1:0] {
      CMD_PUSH_FRONT = 2'd0,
      CMD_PUSH_REAR  = 2'd1,
      CMD_POP_FRONT  = 2'd2,
      CMD_POP_REAR   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_OVERFLOW  = 2'd1,
      STATUS_UNDERFLOW = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE    = 2'd0,
      ST_EXEC    = 2'd1,
      ST_RESPOND = 2'd2
   } state_type;

   typedef struct packed {
      cmd_type                    cmd;
      logic signed [VALUE_W-1:0]  push_value;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0]  pop_value;
      status_type                 status;
      logic [OCC_W-1:0]           occupancy;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic exec;
      logic respond;
   } ctrl_cmd_type;

endpackage

>>> design/circular_deque_unit.sv
// Top level of the circular deque unit: controller, datapath and entry store.
//
//   Channel    Ports                        Direction  Handshake
//   command    start, busy, req_item        in         start high and busy low
//   result     rsp_strobe, rsp_item         out        one-cycle strobe
//
// A command passes through the controller states in order: the transfer in ST_IDLE,
// ST_EXEC, which updates the indices and issues the store write or read, and
// ST_RESPOND, which shows the result; the registered read port of the store needs it.
// busy stays high from the transfer until the result cycle has ended.
// Synchronous reset empties the deque at once; store contents are not cleared.
// The receiver cannot stall; each result is valid for its strobe cycle only.
module circular_deque_unit #(
   parameter int DEPTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  cdq_pkg::req_type req_item,
   output logic             rsp_strobe,
   output cdq_pkg::rsp_type rsp_item
);

   import cdq_pkg::*;

   ctrl_cmd_type ctrl_cmd;

   cdq_controller u_controller (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .busy    (busy),
      .ctrl_cmd(ctrl_cmd)
   );

   cdq_datapath #(
      .DEPTH(DEPTH)
   ) u_datapath (
      .clock   (clock),
      .reset   (reset),
      .ctrl_cmd(ctrl_cmd),
      .req_item(req_item),
      .rsp_item(rsp_item)
   );

   assign rsp_strobe = ctrl_cmd.respond;

endmodule

>>> design/cdq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module cdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/cdq_controller.sv
// Command sequencer for the circular deque unit.
`include "circular_deque_unit_defines.svh"

module cdq_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   output cdq_pkg::ctrl_cmd_type ctrl_cmd
);

   import cdq_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC:    state_in = ST_RESPOND;
         ST_RESPOND: state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      busy             = 1'b1;
      ctrl_cmd.load    = 1'b0;
      ctrl_cmd.exec    = 1'b0;
      ctrl_cmd.respond = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy          = 1'b0;
            ctrl_cmd.load = start;
         end
         ST_EXEC:    ctrl_cmd.exec    = 1'b1;
         ST_RESPOND: ctrl_cmd.respond = 1'b1;
         default:    busy             = 1'b1;
      endcase
   end

   `CDQ_ASSERT(a_load_then_exec, ctrl_cmd.load |=> ctrl_cmd.exec, "transfer not executed")
   `CDQ_ASSERT(a_exec_then_respond, ctrl_cmd.exec |=> ctrl_cmd.respond, "execute without result")
   `CDQ_ASSERT_ALWAYS(a_one_phase, $onehot0({ctrl_cmd.load, ctrl_cmd.exec, ctrl_cmd.respond}),
      "overlapping controller phases")

endmodule

>>> design/cdq_datapath.sv
// Index, count and result registers of the circular deque unit.
`include "circular_deque_unit_defines.svh"

module cdq_datapath #(
   parameter int DEPTH = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cdq_pkg::ctrl_cmd_type ctrl_cmd,
   input  cdq_pkg::req_type      req_item,
   output cdq_pkg::rsp_type      rsp_item
);

   import cdq_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   cmd_type                  cmd_ff;
   logic [VALUE_W-1:0]       value_ff;
   logic [IDX_W-1:0]         front_ff, front_in;
   logic [IDX_W-1:0]         rear_ff, rear_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   status_type               status_ff, status_in;
   logic                     pop_ok_ff, pop_ok_in;

   logic                     wr_en;
   logic [IDX_W-1:0]         wr_addr;
   logic                     rd_en;
   logic [IDX_W-1:0]         rd_addr;
   logic [VALUE_W-1:0]       rd_data;

   logic                     is_push;
   logic                     empty;
   logic                     full;

   function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
      return (idx == IDX_LAST) ? '0 : idx + IDX_W'(1);
   endfunction

   function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] idx);
      return (idx == '0) ? IDX_LAST : idx - IDX_W'(1);
   endfunction

   assign is_push = (cmd_ff == CMD_PUSH_FRONT) || (cmd_ff == CMD_PUSH_REAR);
   assign empty   = (count_ff == '0);
   assign full    = (count_ff == CNT_FULL);

   always_comb begin
      front_in  = front_ff;
      rear_in   = rear_ff;
      count_in  = count_ff;
      status_in = status_ff;
      pop_ok_in = pop_ok_ff;
      wr_en     = 1'b0;
      wr_addr   = '0;
      rd_en     = 1'b0;
      rd_addr   = front_ff;
      if (ctrl_cmd.exec) begin
         status_in = STATUS_OK;
         pop_ok_in = 1'b0;
         if (is_push) begin
            if (full) begin
               status_in = STATUS_OVERFLOW;
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + CNT_W'(1);
               if (empty) begin
                  // first entry always lands in slot zero
                  front_in = '0;
                  rear_in  = '0;
                  wr_addr  = '0;
               end else if (cmd_ff == CMD_PUSH_FRONT) begin
                  front_in = idx_dec(front_ff);
                  wr_addr  = idx_dec(front_ff);
               end else begin
                  rear_in = idx_inc(rear_ff);
                  wr_addr = idx_inc(rear_ff);
               end
            end
         end else begin
            if (empty) begin
               status_in = STATUS_UNDERFLOW;
            end else begin
               pop_ok_in = 1'b1;
               rd_en     = 1'b1;
               rd_addr   = (cmd_ff == CMD_POP_FRONT) ? front_ff : rear_ff;
               count_in  = count_ff - CNT_W'(1);
               if (front_ff == rear_ff) begin
                  front_in = '0;
                  rear_in  = '0;
               end else if (cmd_ff == CMD_POP_FRONT) begin
                  front_in = idx_inc(front_ff);
               end else begin
                  rear_in = idx_dec(rear_ff);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         rear_ff  <= '0;
         count_ff <= '0;
      end else begin
         front_ff <= front_in;
         rear_ff  <= rear_in;
         count_ff <= count_in;
      end
   end

   // Hold the command and the result fields; no reset needed.
   always_ff @(posedge clock) begin
      if (ctrl_cmd.load) begin
         cmd_ff   <= req_item.cmd;
         value_ff <= req_item.push_value;
      end
      status_ff <= status_in;
      pop_ok_ff <= pop_ok_in;
   end

   cdq_ram #(
      .WIDTH(VALUE_W),
      .DEPTH(DEPTH)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(value_ff),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign rsp_item.pop_value = pop_ok_ff ? rd_data : '0;
   assign rsp_item.status    = status_ff;
   assign rsp_item.occupancy = OCC_W'(count_ff);

   `CDQ_ASSERT(a_count_bound, count_ff <= CNT_FULL, "occupancy beyond depth")
   `CDQ_ASSERT(a_underflow,
      (ctrl_cmd.exec && !is_push && empty) |=> (status_ff == STATUS_UNDERFLOW),
      "pop on empty deque not flagged")
   `CDQ_ASSERT(a_overflow_hold, (ctrl_cmd.exec && is_push && full) |=> (count_ff == CNT_FULL),
      "push on full deque changed occupancy")

endmodule
